FILE: rtl/core/lvmt_pkg.sv
// shared constants, codes and control types of the lowest index value match table
`timescale 1ns / 1ps

package lvmt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SLOT_W      = 8;
    localparam int IN_VALUE_W  = 32;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 8;

    localparam logic OP_CHANGE = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic write;
        logic start;
        logic issue;
        logic capture;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic issued_all;
        logic hit;
        logic cmp_last;
    } dp_status_t;

endpackage

FILE: rtl/core/lvmt_dp.sv
// datapath: value memory, valid bits, scan pipeline and result registers
`timescale 1ns / 1ps

module lvmt_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lvmt_pkg::ctl_cmd_t             cmd,
    input  logic [lvmt_pkg::SLOT_W-1:0]     in_slot,
    input  logic signed [lvmt_pkg::IN_VALUE_W-1:0] in_value,
    output lvmt_pkg::dp_status_t           status,
    output logic                           out_found,
    output logic [lvmt_pkg::SLOT_W-1:0]     out_index
);
    import lvmt_pkg::*;

    logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [VALUE_WIDTH-1:0] in_key;
    logic                   in_range;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       rd_addr;

    logic [IDX_W:0]         addr_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic                   cmp_en_reg;
    logic                   cmp_last_reg;
    logic [IDX_W-1:0]       cmp_addr_reg;
    logic                   res_found_reg;
    logic [SLOT_W-1:0]      res_index_reg;
    logic                   found_out_reg;
    logic [SLOT_W-1:0]      index_out_reg;
    logic                   hit;

    assign in_key   = VALUE_WIDTH'($unsigned(in_value));
    assign in_range = (32'(in_slot) < TABLE_DEPTH);
    assign wr_addr  = IDX_W'(in_slot);
    assign rd_addr  = addr_reg[IDX_W-1:0];

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.write && in_range) begin
            mem[wr_addr] <= in_key;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.write && in_range) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg   <= '0;
            cmp_en_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.issue;
            if (cmd.start) begin
                addr_reg <= '0;
            end else if (cmd.issue) begin
                addr_reg <= addr_reg + (IDX_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg <= in_key;
        end
        rd_valid_reg <= valid_reg[rd_addr];
        cmp_addr_reg <= rd_addr;
        cmp_last_reg <= (addr_reg == (IDX_W+1)'(TABLE_DEPTH - 1));
        if (cmd.capture) begin
            res_found_reg <= hit;
            res_index_reg <= hit ? SLOT_W'(cmp_addr_reg) : '0;
        end
        if (cmd.load_out) begin
            found_out_reg <= res_found_reg;
            index_out_reg <= res_index_reg;
        end
    end

    assign hit = cmp_en_reg && rd_valid_reg && (rd_data_reg == key_reg);

    assign status.issued_all = (addr_reg == (IDX_W+1)'(TABLE_DEPTH));
    assign status.hit        = hit;
    assign status.cmp_last   = cmp_en_reg && cmp_last_reg;

    assign out_found = found_out_reg;
    assign out_index = index_out_reg;

endmodule

FILE: rtl/core/lvmt_ctrl.sv
// controller: request handshake, scan sequencing and output valid
`timescale 1ns / 1ps

module lvmt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_opcode,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  lvmt_pkg::dp_status_t status,
    output lvmt_pkg::ctl_cmd_t   cmd
);
    import lvmt_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   scan_end;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign scan_end = status.hit || status.cmp_last;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd.write     = 1'b0;
        cmd.start     = 1'b0;
        cmd.issue     = 1'b0;
        cmd.capture   = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_FIND) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.issue = !status.issued_all;
                if (scan_end) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/core/lowest_index_value_match_table_core.sv
// top level of the lowest index value match table: controller plus datapath
`timescale 1ns / 1ps
// change request: accepted while idle, memory written at the accepting edge, no result
// find request: scans slots from 0 through one memory read port, one slot a cycle;
//   result captured at the lowest matching slot m, or after slot TABLE_DEPTH-1 if none
// next request accepted once a find's result has moved into a free output register
// one find in flight at a time; a waiting result sits in the output register
// reset (aresetn low, synchronous) clears all valid bits at once: no clearing pass

module lowest_index_value_match_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] slot_index, [39:8] value
    input  logic [0:0]  s_tuser,   // [0] opcode
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] match_index
    output logic [0:0]  m_tuser    // [0] found
);
    import lvmt_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    logic                          in_opcode;
    logic [SLOT_W-1:0]             in_slot;
    logic signed [IN_VALUE_W-1:0]  in_value;
    logic                          out_found;
    logic [SLOT_W-1:0]             out_index;

    // unpack the request
    assign in_opcode = s_tuser[0];
    assign in_slot   = s_tdata[SLOT_W-1:0];
    assign in_value  = $signed(s_tdata[S_DATA_W-1:SLOT_W]);

    // sequencing: accept, scan, hand over to the output register
    lvmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_opcode (in_opcode),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage, compare pipeline and result payload
    lvmt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_slot   (in_slot),
        .in_value  (in_value),
        .status    (status),
        .out_found (out_found),
        .out_index (out_index)
    );

    // pack the result
    assign m_tdata    = out_index;
    assign m_tuser[0] = out_found;

    // a miss always reports slot zero
    a_miss_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss result with nonzero match index");

    // a change request never produces a result
    a_change_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == OP_CHANGE) && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared after a change request");

    // a find request blocks new requests while the scan runs
    a_find_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == OP_FIND)) |=> !s_tready)
        else $error("request accepted during a scan");

    // the scan stops issuing after a capture command
    a_scan_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !cmd.issue)
        else $error("scan kept issuing after capture");

endmodule

FILE: verif/tb_top.sv
// self-checking testbench of the lowest index value match table core
`timescale 1ns / 1ps

module tb_top;
    import lvmt_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1730;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
    localparam int POOL_SIZE    = 12;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_LIMIT  = 20_000;
    localparam int TAIL_CYCLES  = TABLE_DEPTH + 8;
    localparam int PRINT_LIMIT  = 100;
    localparam int NUM_DIRECTED = 21;

    localparam logic [IN_VALUE_W-1:0] INT_MIN   = 32'h8000_0000;
    localparam logic [IN_VALUE_W-1:0] INT_MAX   = 32'h7fff_ffff;
    localparam logic [IN_VALUE_W-1:0] MINUS_ONE = 32'hffff_ffff;

    typedef struct packed {
        logic             found;
        logic [SLOT_W-1:0] index;
    } match_t;

    // typed rows carry their expected result, the others go through the predictor
    typedef struct packed {
        logic                  op;
        logic [SLOT_W-1:0]     slot;
        logic [IN_VALUE_W-1:0] value;
        logic                  typed;
        logic                  exp_found;
        logic [SLOT_W-1:0]     exp_index;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{OP_FIND,   8'd0,   32'd0,        1'b1, 1'b0, 8'd0},    // empty table
        '{OP_FIND,   8'd255, INT_MIN,      1'b1, 1'b0, 8'd0},    // empty table
        '{OP_CHANGE, 8'd0,   INT_MAX,      1'b0, 1'b0, 8'd0},
        '{OP_CHANGE, 8'd255, INT_MIN,      1'b0, 1'b0, 8'd0},
        '{OP_FIND,   8'd17,  INT_MAX,      1'b1, 1'b1, 8'd0},    // first slot
        '{OP_FIND,   8'd0,   INT_MIN,      1'b1, 1'b1, 8'd255},  // last slot
        '{OP_CHANGE, 8'd10,  32'd5,        1'b0, 1'b0, 8'd0},
        '{OP_CHANGE, 8'd3,   32'd5,        1'b0, 1'b0, 8'd0},
        '{OP_FIND,   8'd0,   32'd5,        1'b0, 1'b0, 8'd0},    // two matches, lower wins
        '{OP_CHANGE, 8'd3,   32'd6,        1'b0, 1'b0, 8'd0},    // rewrite a valid slot
        '{OP_FIND,   8'd0,   32'd5,        1'b0, 1'b0, 8'd0},
        '{OP_FIND,   8'd0,   32'd6,        1'b0, 1'b0, 8'd0},
        '{OP_FIND,   8'd0,   32'd0,        1'b1, 1'b0, 8'd0},    // unwritten slots never match
        '{OP_CHANGE, 8'd128, 32'd0,        1'b0, 1'b0, 8'd0},
        '{OP_FIND,   8'd0,   32'd0,        1'b0, 1'b0, 8'd0},
        '{OP_CHANGE, 8'd0,   MINUS_ONE,    1'b0, 1'b0, 8'd0},
        '{OP_FIND,   8'd0,   MINUS_ONE,    1'b1, 1'b1, 8'd0},
        '{OP_FIND,   8'd0,   INT_MAX,      1'b1, 1'b0, 8'd0},    // old value overwritten
        '{OP_CHANGE, 8'd255, 32'd5,        1'b0, 1'b0, 8'd0},
        '{OP_FIND,   8'd0,   32'd5,        1'b0, 1'b0, 8'd0},
        '{OP_FIND,   8'd0,   32'h1234_5678, 1'b1, 1'b0, 8'd0}    // never written
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;

    // predictor state and pending find results, oldest first
    logic [VALUE_WIDTH-1:0] table_value [TABLE_DEPTH];
    bit                     table_valid [TABLE_DEPTH];
    match_t                 pending_matches [$];
    match_t                 oldest_match;

    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_request;
    int error_count;
    int cycle_count;

    lowest_index_value_match_table_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        error_count++;
    endtask

    function automatic match_t find_lowest_match(input logic [IN_VALUE_W-1:0] key);
        match_t hit;
        hit = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!hit.found && table_valid[i] && table_value[i] == key[VALUE_WIDTH-1:0]) begin
                hit.found = 1'b1;
                hit.index = SLOT_W'(i);
            end
        end
        return hit;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot,
                                input logic [IN_VALUE_W-1:0] value, input logic typed,
                                input logic exp_found, input logic [SLOT_W-1:0] exp_index);
        match_t expected;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {value, slot};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_CHANGE) begin
            // slots beyond the table are dropped
            if (int'(slot) < TABLE_DEPTH) begin
                table_value[slot] = value[VALUE_WIDTH-1:0];
                table_valid[slot] = 1'b1;
            end
        end else begin
            if (typed) begin
                expected.found = exp_found;
                expected.index = exp_index;
            end else begin
                expected = find_lowest_match(value);
            end
            pending_matches.push_back(expected);
        end
        @(negedge aclk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request != hold_seen) begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_matches.size() == 0) begin
                report_mismatch("result with no find outstanding");
            end else begin
                oldest_match = pending_matches.pop_front();
                if (m_tuser[0] !== oldest_match.found) begin
                    report_mismatch($sformatf("found %b, predicted %b",
                                              m_tuser[0], oldest_match.found));
                end
                if (m_tdata !== oldest_match.index) begin
                    report_mismatch($sformatf("match_index %0d, predicted %0d",
                                              m_tdata, oldest_match.index));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        logic [IN_VALUE_W-1:0] value_pool [POOL_SIZE];
        logic [IN_VALUE_W-1:0] rand_value;
        logic [SLOT_W-1:0]     rand_slot;
        logic                  rand_op;
        int                    drain;

        aresetn           = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        s_tuser           = '0;
        sender_idle_pct   = 8;
        receiver_idle_pct = 79;
        hold_request      = 0;
        error_count       = 0;
        cycle_count       = 0;

        // a few extreme values, the rest random, so finds hit often
        value_pool[0] = 32'd0;
        value_pool[1] = MINUS_ONE;
        value_pool[2] = INT_MIN;
        value_pool[3] = INT_MAX;
        for (int i = 4; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom;
        end

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].slot, DIRECTED_ROWS[r].value,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp_found,
                         DIRECTED_ROWS[r].exp_index);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 8;
                    receiver_idle_pct = 79;
                end
                1: begin
                    sender_idle_pct   = 79;
                    receiver_idle_pct = 8;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                    // long hold-off on the result side to back up the input
                    hold_request++;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rand_op    = ($urandom_range(1) == 0) ? OP_CHANGE : OP_FIND;
                rand_value = ($urandom_range(99) < 80) ? value_pool[$urandom_range(POOL_SIZE - 1)]
                                                       : $urandom;
                // half the writes land low so matches spread over short and long scans
                rand_slot  = ($urandom_range(1) == 0) ? SLOT_W'($urandom_range(15))
                                                      : SLOT_W'($urandom_range(255));
                send_request(rand_op, rand_slot, rand_value, 1'b0, 1'b0, '0);
            end
        end

        s_tvalid = 1'b0;
        drain    = 0;
        while (pending_matches.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_matches.size() != 0) begin
            report_mismatch($sformatf("%0d find results never arrived", pending_matches.size()));
        end

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
